// ----- src/sact_pkg.sv -----
package sact_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED   = 2'd2;

    // fixed field widths
    localparam int CNT_W     = 32;
    localparam int WAY_OUT_W = 3;
    localparam int WAY_MAX_W = 4;
    localparam int WAYS_W    = 5;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    // lookup outcome handed from the compare logic to the controller
    typedef struct packed {
        logic                 hit;
        logic [WAY_MAX_W-1:0] way;
    } lookup_t;

endpackage

// ----- src/sact_tag_mem.sv -----
module sact_tag_mem #(
    parameter int ROW_W  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sact_lookup.sv -----
module sact_lookup #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_WAYS  = 8,
    parameter int CUR_W     = 3
) (
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] row_tags,
    input  logic [MAX_WAYS-1:0]                row_valid,
    input  logic [CUR_W-1:0]                   row_cursor,
    input  logic [ADDR_BITS-1:0]               tag,
    input  logic [sact_pkg::WAYS_W-1:0]        ways_eff,
    output sact_pkg::lookup_t                  result,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tags,
    output logic [MAX_WAYS-1:0]                new_valid,
    output logic [CUR_W-1:0]                   new_cursor
);

    logic [MAX_WAYS-1:0]         hit_vec;
    logic [CUR_W-1:0]            hit_way;
    logic [CUR_W-1:0]            victim;
    logic [sact_pkg::WAYS_W-1:0] victim_inc;

    // compare all ways in use at once
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hit_vec[w] = (sact_pkg::WAYS_W'(w) < ways_eff) && row_valid[w]
                         && (row_tags[w] == tag);
        end
    end

    // lowest matching way wins
    always_comb
    begin
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = CUR_W'(w);
            end
        end
    end

    // victim under the cursor, stale cursor falls back to way 0
    always_comb
    begin
        if (sact_pkg::WAYS_W'(row_cursor) >= ways_eff)
        begin
            victim = '0;
        end
        else
        begin
            victim = row_cursor;
        end
        victim_inc = sact_pkg::WAYS_W'(victim) + sact_pkg::WAYS_W'(1);
        if (victim_inc >= ways_eff)
        begin
            new_cursor = '0;
        end
        else
        begin
            new_cursor = victim_inc[CUR_W-1:0];
        end
    end

    // refill of the victim way
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (CUR_W'(w) == victim)
            begin
                new_tags[w]  = tag;
                new_valid[w] = 1'b1;
            end
            else
            begin
                new_tags[w]  = row_tags[w];
                new_valid[w] = row_valid[w];
            end
        end
    end

    assign result.hit = |hit_vec;
    assign result.way = (|hit_vec) ? sact_pkg::WAY_MAX_W'(hit_way)
                                   : sact_pkg::WAY_MAX_W'(victim);

endmodule

// ----- src/set_assoc_cache_tag_lookup.sv -----
// set-associative tag lookup with round-robin refill
// out_valid rises when RESOLVE ends; RESOLVE waits while an older result is unaccepted
// an address is taken only in IDLE: its tag row is read, then written back on a miss
// a result waiting in the output register does not block the next lookup's read
// reset: a clearing pass over every set wipes valid bits and cursors, in_ready stays low
module set_assoc_cache_tag_lookup #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [sact_pkg::WAY_OUT_W-1:0]    way_number,
    output logic [sact_pkg::CNT_W-1:0]        request_count,
    output logic [sact_pkg::CNT_W-1:0]        miss_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sact_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int CUR_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EXT_W   = (ADDR_BITS > SET_W) ? ADDR_BITS : SET_W;
    localparam int ROW_W   = CUR_W + MAX_WAYS + MAX_WAYS * ADDR_BITS;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

    // configuration registers
    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_used_reg;

    // control
    sact_pkg::state_t state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [sact_pkg::CNT_W-1:0] req_cnt_reg, req_cnt_next;
    logic [sact_pkg::CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    // payload
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic                 hit_reg;
    logic [sact_pkg::WAY_OUT_W-1:0] way_reg;

    // address decode
    logic [3:0]           ib_eff;
    logic [5:0]           tag_shift;
    logic [ADDR_BITS-1:0] addr_trim;
    logic [EXT_W-1:0]     addr_shifted;
    logic [EXT_W-1:0]     set_full;
    logic [SET_W-1:0]     in_set;
    logic [ADDR_BITS-1:0] in_tag;
    logic [sact_pkg::WAYS_W-1:0] ways_eff;

    // memory and lookup
    logic                 mem_wr_en;
    logic [SET_W-1:0]     mem_wr_addr;
    logic [ROW_W-1:0]     mem_wr_data;
    logic                 mem_rd_en;
    logic [ROW_W-1:0]     mem_rd_data;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_tags, wb_tags;
    logic [MAX_WAYS-1:0]  rd_valid, wb_valid;
    logic [CUR_W-1:0]     rd_cursor, wb_cursor;
    sact_pkg::lookup_t    lk;
    logic                 in_beat;
    logic                 finish;

    // effective geometry
    always_comb
    begin
        if ({1'b0, index_bits_reg} > 5'(IDX_MAX))
        begin
            ib_eff = 4'(IDX_MAX);
        end
        else
        begin
            ib_eff = index_bits_reg;
        end
        if (ways_used_reg == 4'd0)
        begin
            ways_eff = sact_pkg::WAYS_W'(1);
        end
        else if ({1'b0, ways_used_reg} > sact_pkg::WAYS_W'(MAX_WAYS))
        begin
            ways_eff = sact_pkg::WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = {1'b0, ways_used_reg};
        end
    end

    // set index and tag of the incoming address
    always_comb
    begin
        addr_trim    = address[ADDR_BITS-1:0];
        addr_shifted = EXT_W'(addr_trim) >> offset_bits_reg;
        set_full     = addr_shifted & ~({EXT_W{1'b1}} << ib_eff);
        in_set       = set_full[SET_W-1:0];
        tag_shift    = 6'(offset_bits_reg) + 6'(ib_eff);
        in_tag       = addr_trim & ({ADDR_BITS{1'b1}} << tag_shift);
    end

    assign in_beat = in_valid && in_ready;
    assign finish  = (state_reg == sact_pkg::ST_RESOLVE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sact_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = sact_pkg::ST_IDLE;
                end
            end
            sact_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sact_pkg::ST_RESOLVE;
                end
            end
            sact_pkg::ST_RESOLVE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = sact_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sact_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs and memory port control
    always_comb
    begin
        in_ready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = set_reg;
        mem_wr_data = {wb_cursor, wb_valid, wb_tags};
        unique case (state_reg)
            sact_pkg::ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                mem_wr_data = '0;
            end
            sact_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_rd_en = in_valid;
            end
            sact_pkg::ST_RESOLVE:
            begin
                mem_wr_en = (!out_valid_reg || out_ready) && !lk.hit;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // tag rows: cursor, valid bits and tags of one set
    sact_tag_mem #(
        .ROW_W  (ROW_W),
        .DEPTH  (MAX_SETS),
        .ADDR_W (SET_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (in_set),
        .rd_data (mem_rd_data)
    );

    assign {rd_cursor, rd_valid, rd_tags} = mem_rd_data;

    sact_lookup #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_WAYS  (MAX_WAYS),
        .CUR_W     (CUR_W)
    ) u_lookup (
        .row_tags   (rd_tags),
        .row_valid  (rd_valid),
        .row_cursor (rd_cursor),
        .tag        (tag_reg),
        .ways_eff   (ways_eff),
        .result     (lk),
        .new_tags   (wb_tags),
        .new_valid  (wb_valid),
        .new_cursor (wb_cursor)
    );

    // counters and output valid
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        req_cnt_next   = req_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        out_valid_next = out_valid_reg;
        if (state_reg == sact_pkg::ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + SET_W'(1);
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
            if (req_cnt_reg != '1)
            begin
                req_cnt_next = req_cnt_reg + sact_pkg::CNT_W'(1);
            end
            if (!lk.hit && (miss_cnt_reg != '1))
            begin
                miss_cnt_next = miss_cnt_reg + sact_pkg::CNT_W'(1);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sact_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            req_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            req_cnt_reg   <= req_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 5'd2;
            index_bits_reg  <= 4'd8;
            ways_used_reg   <= 4'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sact_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                sact_pkg::REG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                sact_pkg::REG_WAYS_USED:   ways_used_reg   <= cfg_data[3:0];
                default:                   offset_bits_reg <= offset_bits_reg;
            endcase
        end
    end

    // captured lookup and result payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
        if (finish)
        begin
            hit_reg <= lk.hit;
            way_reg <= lk.way[sact_pkg::WAY_OUT_W-1:0];
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign way_number    = way_reg;
    assign request_count = req_cnt_reg;
    assign miss_count    = miss_cnt_reg;

endmodule
